// ===== design/first_fit_heap_allocator_core_macros.svh =====
// Assertion macros for the first-fit heap allocator core.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication on clk, disabled while arst_n is low.
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, disabled while arst_n is low.
`define FFHA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ffha_pkg.sv =====
// Types, codes and constants shared by the first-fit heap allocator modules.
package ffha_pkg;

	localparam int unsigned HDR_BYTES = 4;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OVERSIZE = 3'd1;
	localparam logic [2:0] ST_NOSPACE  = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_CORRUPT  = 3'd4;

	// arena access commands
	localparam logic [3:0] ACC_NONE       = 4'd0;
	localparam logic [3:0] ACC_RD_HDR_OFF = 4'd1;
	localparam logic [3:0] ACC_RD_HDR_END = 4'd2;
	localparam logic [3:0] ACC_RD_FOOT    = 4'd3;
	localparam logic [3:0] ACC_RD_HDR_PRV = 4'd4;
	localparam logic [3:0] ACC_WR_NH_CLR  = 4'd5;
	localparam logic [3:0] ACC_WR_NH_SET  = 4'd6;
	localparam logic [3:0] ACC_WR_TAKE    = 4'd7;
	localparam logic [3:0] ACC_WR_SPLIT   = 4'd8;
	localparam logic [3:0] ACC_WR_SPL_FT  = 4'd9;
	localparam logic [3:0] ACC_WR_NOFF    = 4'd10;
	localparam logic [3:0] ACC_WR_REL_HDR = 4'd11;
	localparam logic [3:0] ACC_WR_REL_FT  = 4'd12;
	localparam logic [3:0] ACC_WR_PRV_HDR = 4'd13;
	localparam logic [3:0] ACC_WR_PRV_FT  = 4'd14;

	// datapath register updates
	localparam logic [4:0] UPD_NONE   = 5'd0;
	localparam logic [4:0] UPD_LOAD   = 5'd1;
	localparam logic [4:0] UPD_RND1   = 5'd2;
	localparam logic [4:0] UPD_RND2   = 5'd3;
	localparam logic [4:0] UPD_RND3   = 5'd4;
	localparam logic [4:0] UPD_CLAMP  = 5'd5;
	localparam logic [4:0] UPD_LD_HDR = 5'd6;
	localparam logic [4:0] UPD_ADV    = 5'd7;
	localparam logic [4:0] UPD_LD_NH  = 5'd8;
	localparam logic [4:0] UPD_TAKE   = 5'd9;
	localparam logic [4:0] UPD_SPLIT  = 5'd10;
	localparam logic [4:0] UPD_LD_P   = 5'd11;
	localparam logic [4:0] UPD_LD_PH  = 5'd12;
	localparam logic [4:0] UPD_MERGE  = 5'd13;
	localparam logic [4:0] UPD_LD_PH2 = 5'd14;
	localparam logic [4:0] UPD_FREED4 = 5'd15;
	localparam logic [4:0] UPD_FT_ADD = 5'd16;
	localparam logic [4:0] UPD_FIN    = 5'd17;

	typedef struct packed {
		logic        action;
		logic [15:0] request_bytes;
		logic [11:0] release_offset;
	} item_t;

	typedef struct packed {
		logic [11:0] payload_offset;
		logic [2:0]  status;
		logic [11:0] free_bytes;
	} result_t;

	typedef struct packed {
		logic [3:0] acc;
		logic [4:0] upd;
		logic [2:0] st;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic act;
		logic oversize;
		logic end_over;
		logic hfree;
		logic fits;
		logic has_next;
		logic match;
		logic small_blk;
		logic next_over;
		logic has_prev;
		logic off_lt_pb;
		logic p_bad;
		logic prev_bad;
	} flags_t;

endpackage

// ===== design/first_fit_heap_allocator_core.sv =====
// Top level of the first-fit boundary-tag heap allocator core.
// One command is taken when start is high and busy is low; its single result
// appears on response for exactly one cycle with strobe high, and must be
// taken then, as the core cannot be held off. Commands run one at a time.
// The arena is a byte-wide memory with one port, accessed one byte per step, so
// every header read is an issue step, a step per header byte, the registered
// memory read and byte assembly, then load and evaluate. An allocate walks the
// blocks, then reads the next header, if any, and updates the chosen block; a
// release walks the blocks, then checks the neighbors and merges, with footers
// of POINTER_BYTES bytes each. No clearing pass is needed after reset: only
// the first header comes from reset, the rest of the arena is defined by writes.
`include "first_fit_heap_allocator_core_macros.svh"

module first_fit_heap_allocator_core #(
	parameter int unsigned ARENA_BYTES     = 4096,
	parameter int unsigned ALIGN_BYTES     = 4,
	parameter int unsigned MIN_BLOCK_BYTES = 8,
	parameter int unsigned POINTER_BYTES   = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ffha_pkg::item_t   request,
	output ffha_pkg::result_t response,
	output logic              strobe
);
	import ffha_pkg::*;

	logic   accept;
	logic   fail_strobe;
	cmd_t   cmd;
	flags_t flags;

	assign accept = start && !busy;
	assign fail_strobe = strobe && (response.status != ST_OK);

	ffha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.flags  (flags),
		.cmd    (cmd),
		.busy   (busy)
	);

	ffha_dp #(
		.ARENA_BYTES     (ARENA_BYTES),
		.ALIGN_BYTES     (ALIGN_BYTES),
		.MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
		.POINTER_BYTES   (POINTER_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.cmd      (cmd),
		.flags    (flags),
		.response (response),
		.strobe   (strobe)
	);

	`FFHA_ASSERT_IMP(a_strobe_idle, strobe, !busy, "result strobed while busy")
	`FFHA_ASSERT_NXT(a_accept_busy, accept, busy, "accepted transaction did not start")
	`FFHA_ASSERT_NXT(a_single_strobe, strobe, !strobe, "result strobed twice")
	`FFHA_ASSERT_IMP(a_fail_zero, fail_strobe, response.payload_offset == 12'd0, "offset on failure")

endmodule

// ===== design/ffha_ctrl.sv =====
// Sequencer for the allocate and release walks over the arena.
module ffha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  ffha_pkg::flags_t flags,
	output ffha_pkg::cmd_t  cmd,
	output logic            busy
);
	import ffha_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_RND1 = 5'd1;
	localparam logic [4:0] S_RND2 = 5'd2;
	localparam logic [4:0] S_RND3 = 5'd3;
	localparam logic [4:0] S_CHK  = 5'd4;
	localparam logic [4:0] S_HRD  = 5'd5;
	localparam logic [4:0] S_WAIT = 5'd6;
	localparam logic [4:0] S_HLD  = 5'd7;
	localparam logic [4:0] S_HEV  = 5'd8;
	localparam logic [4:0] S_NLD  = 5'd9;
	localparam logic [4:0] S_NEV  = 5'd10;
	localparam logic [4:0] S_ATK  = 5'd11;
	localparam logic [4:0] S_SPF  = 5'd12;
	localparam logic [4:0] S_SPH  = 5'd13;
	localparam logic [4:0] S_RPV  = 5'd14;
	localparam logic [4:0] S_RPL  = 5'd15;
	localparam logic [4:0] S_RPE  = 5'd16;
	localparam logic [4:0] S_RPH  = 5'd17;
	localparam logic [4:0] S_RPC  = 5'd18;
	localparam logic [4:0] S_RMG  = 5'd19;
	localparam logic [4:0] S_RM2  = 5'd20;
	localparam logic [4:0] S_RM3  = 5'd21;
	localparam logic [4:0] S_RM4  = 5'd22;
	localparam logic [4:0] S_RM5  = 5'd23;
	localparam logic [4:0] S_RM6  = 5'd24;
	localparam logic [4:0] S_RM7  = 5'd25;
	localparam logic [4:0] S_RFT  = 5'd26;
	localparam logic [4:0] S_FIN  = 5'd27;

	logic [4:0] state_q, state_d;
	logic [4:0] ret_q, ret_d;
	logic [2:0] st_q, st_d;

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		st_d    = st_q;
		cmd.acc = ACC_NONE;
		cmd.upd = UPD_NONE;
		cmd.st  = st_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.upd = UPD_LOAD;
					state_d = S_RND1;
				end
			end
			S_RND1: begin
				cmd.upd = UPD_RND1;
				state_d = S_RND2;
			end
			S_RND2: begin
				cmd.upd = UPD_RND2;
				state_d = S_RND3;
			end
			S_RND3: begin
				cmd.upd = UPD_RND3;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (flags.act) begin
					state_d = S_HRD;
				end else if (flags.oversize) begin
					st_d    = ST_OVERSIZE;
					state_d = S_FIN;
				end else begin
					cmd.upd = UPD_CLAMP;
					state_d = S_HRD;
				end
			end
			S_HRD: begin
				cmd.acc = ACC_RD_HDR_OFF;
				ret_d   = S_HLD;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (flags.done)
					state_d = ret_q;
			end
			S_HLD: begin
				cmd.upd = UPD_LD_HDR;
				state_d = S_HEV;
			end
			S_HEV: begin
				if (flags.end_over) begin
					st_d    = ST_CORRUPT;
					state_d = S_FIN;
				end else if ((!flags.act && (!flags.hfree || !flags.fits)) ||
					(flags.act && !flags.match)) begin
					// advance to the next block; the arena end closes the walk
					cmd.upd = UPD_ADV;
					if (!flags.has_next) begin
						st_d    = flags.act ? ST_NOTFOUND : ST_NOSPACE;
						state_d = S_FIN;
					end else begin
						state_d = S_HRD;
					end
				end else if (flags.act && flags.hfree) begin
					st_d    = ST_NOTFOUND;
					state_d = S_FIN;
				end else if (flags.has_next) begin
					cmd.acc = ACC_RD_HDR_END;
					ret_d   = S_NLD;
					state_d = S_WAIT;
				end else begin
					state_d = flags.act ? S_RPV : S_ATK;
				end
			end
			S_NLD: begin
				cmd.upd = UPD_LD_NH;
				state_d = S_NEV;
			end
			S_NEV: begin
				if (!flags.act) begin
					cmd.acc = ACC_WR_NH_CLR;
					ret_d   = S_ATK;
					state_d = S_WAIT;
				end else if (flags.next_over) begin
					st_d    = ST_CORRUPT;
					state_d = S_FIN;
				end else begin
					state_d = S_RPV;
				end
			end
			S_ATK: begin
				st_d    = ST_OK;
				state_d = S_WAIT;
				if (flags.small_blk) begin
					cmd.acc = ACC_WR_TAKE;
					cmd.upd = UPD_TAKE;
					ret_d   = S_FIN;
				end else begin
					cmd.acc = ACC_WR_SPLIT;
					cmd.upd = UPD_SPLIT;
					ret_d   = S_SPF;
				end
			end
			S_SPF: begin
				cmd.acc = ACC_WR_SPL_FT;
				ret_d   = S_SPH;
				state_d = S_WAIT;
			end
			S_SPH: begin
				cmd.acc = ACC_WR_NOFF;
				ret_d   = S_FIN;
				state_d = S_WAIT;
			end
			S_RPV: begin
				if (!flags.has_prev) begin
					state_d = S_RMG;
				end else if (flags.off_lt_pb) begin
					st_d    = ST_CORRUPT;
					state_d = S_FIN;
				end else begin
					cmd.acc = ACC_RD_FOOT;
					ret_d   = S_RPL;
					state_d = S_WAIT;
				end
			end
			S_RPL: begin
				cmd.upd = UPD_LD_P;
				state_d = S_RPE;
			end
			S_RPE: begin
				if (flags.p_bad) begin
					st_d    = ST_CORRUPT;
					state_d = S_FIN;
				end else begin
					cmd.acc = ACC_RD_HDR_PRV;
					ret_d   = S_RPH;
					state_d = S_WAIT;
				end
			end
			S_RPH: begin
				cmd.upd = UPD_LD_PH;
				state_d = S_RPC;
			end
			S_RPC: begin
				if (flags.prev_bad) begin
					st_d    = ST_CORRUPT;
					state_d = S_FIN;
				end else begin
					state_d = S_RMG;
				end
			end
			S_RMG: begin
				cmd.upd = UPD_MERGE;
				if (flags.has_next) begin
					cmd.acc = ACC_WR_NH_SET;
					ret_d   = S_RM2;
					state_d = S_WAIT;
				end else begin
					state_d = S_RM2;
				end
			end
			S_RM2: begin
				cmd.acc = ACC_WR_REL_HDR;
				ret_d   = S_RM3;
				state_d = S_WAIT;
			end
			S_RM3: begin
				cmd.acc = ACC_WR_REL_FT;
				ret_d   = S_RM4;
				state_d = S_WAIT;
			end
			S_RM4: begin
				if (flags.has_prev) begin
					cmd.acc = ACC_RD_HDR_PRV;
					ret_d   = S_RM5;
					state_d = S_WAIT;
				end else begin
					state_d = S_RFT;
				end
			end
			S_RM5: begin
				cmd.upd = UPD_LD_PH2;
				state_d = S_RM6;
			end
			S_RM6: begin
				cmd.acc = ACC_WR_PRV_HDR;
				ret_d   = S_RM7;
				state_d = S_WAIT;
			end
			S_RM7: begin
				cmd.acc = ACC_WR_PRV_FT;
				cmd.upd = UPD_FREED4;
				ret_d   = S_RFT;
				state_d = S_WAIT;
			end
			S_RFT: begin
				cmd.upd = UPD_FT_ADD;
				st_d    = ST_OK;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.upd = UPD_FIN;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			st_q    <= st_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== design/ffha_dp.sv =====
// Datapath: byte-wide arena memory, access engine, walk registers and result register.
module ffha_dp #(
	parameter int unsigned ARENA_BYTES     = 4096,
	parameter int unsigned ALIGN_BYTES     = 4,
	parameter int unsigned MIN_BLOCK_BYTES = 8,
	parameter int unsigned POINTER_BYTES   = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ffha_pkg::item_t   request,
	input  ffha_pkg::cmd_t    cmd,
	output ffha_pkg::flags_t  flags,
	output ffha_pkg::result_t response,
	output logic              strobe
);
	import ffha_pkg::*;

	localparam int unsigned AW  = $clog2(ARENA_BYTES);
	localparam int unsigned XW  = 17;
	localparam int unsigned SZW = XW + 1;
	localparam int unsigned SH  = XW + $clog2(ALIGN_BYTES);
	localparam int unsigned MUL = ((2 ** SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
	localparam int unsigned MW  = SH + 1;
	localparam logic [31:0] ARENA_W = 32'(ARENA_BYTES);
	localparam logic [31:0] PB_W    = 32'(POINTER_BYTES);
	localparam logic [31:0] HDR_W   = 32'(HDR_BYTES);
	localparam logic [31:0] HDR0    = {30'(ARENA_BYTES - HDR_BYTES), 1'b1, 1'b0};

	// walk registers
	logic              act_q;
	logic [11:0]       rel_q;
	logic [XW-1:0]     x_q;
	logic [XW-1:0]     q_s1;
	logic [SZW-1:0]    sz_q;
	logic [31:0]       off_q, end_q, h_q, nh_q, ph_q, newsize_q, total_q;
	logic [63:0]       p_q;
	logic [12:0]       freed_q, ft_q;
	logic [11:0]       payload_q;
	result_t           res_q;
	logic              strobe_q;

	// access engine
	logic              eng_act_q, eng_wr_q;
	logic [3:0]        cnt_q, len_q;
	logic [31:0]       base_q;
	logic [63:0]       wval_q, asm_q;
	logic              v_s1, last_s1, wr_s1, use_rst_s1, done_q;
	logic [2:0]        idx_s1;
	logic [7:0]        rstb_s1, mem_rd_q;
	logic [3:0]        init_q;
	logic [7:0]        mem [ARENA_BYTES];

	logic [31:0]       sz_w, size_w, nsize_w, psize_w, noff_w;
	logic [31:0]       acc_addr, acc_sum, acc_wrap;
	logic [AW-1:0]     mem_addr;
	logic [63:0]       acc_wval;
	logic              acc_wr, acc_foot;
	logic [XW+MW-1:0]  prod_w;
	logic [7:0]        byte_s1;
	logic [31:0]       merge_add;

	assign sz_w    = 32'(sz_q);
	assign size_w  = {2'b00, h_q[31:2]};
	assign nsize_w = {2'b00, nh_q[31:2]};
	assign psize_w = {2'b00, ph_q[31:2]};
	assign noff_w  = end_q - HDR_W - sz_w;
	assign prod_w  = (XW+MW)'(x_q) * (XW+MW)'(MUL);
	assign merge_add = (nh_q[1] && (end_q < ARENA_W)) ? nsize_w + HDR_W : 32'd0;

	// access address, data and direction per command
	always_comb begin
		acc_addr = off_q;
		acc_wval = 64'd0;
		acc_wr   = 1'b1;
		acc_foot = 1'b0;
		case (cmd.acc)
			ACC_RD_HDR_OFF: acc_wr = 1'b0;
			ACC_RD_HDR_END: begin
				acc_addr = end_q;
				acc_wr   = 1'b0;
			end
			ACC_RD_FOOT: begin
				acc_addr = off_q - PB_W;
				acc_wr   = 1'b0;
				acc_foot = 1'b1;
			end
			ACC_RD_HDR_PRV: begin
				acc_addr = p_q[31:0];
				acc_wr   = 1'b0;
			end
			ACC_WR_NH_CLR: begin
				acc_addr = end_q;
				acc_wval = {32'd0, nh_q[31:1], 1'b0};
			end
			ACC_WR_NH_SET: begin
				acc_addr = end_q;
				acc_wval = {32'd0, nh_q[31:1], 1'b1};
			end
			ACC_WR_TAKE: acc_wval = {32'd0, h_q[31:2], 1'b0, h_q[0]};
			ACC_WR_SPLIT: begin
				acc_wval = {32'd0, 30'(size_w - sz_w - HDR_W), 1'b1, h_q[0]};
			end
			ACC_WR_SPL_FT: begin
				acc_addr = noff_w - PB_W;
				acc_wval = {32'd0, off_q};
				acc_foot = 1'b1;
			end
			ACC_WR_NOFF: begin
				acc_addr = noff_w;
				acc_wval = {32'd0, 30'(sz_w), 1'b0, 1'b1};
			end
			ACC_WR_REL_HDR: acc_wval = {32'd0, newsize_q[29:0], 1'b1, h_q[0]};
			ACC_WR_REL_FT: begin
				acc_addr = off_q + HDR_W + newsize_q - PB_W;
				acc_wval = {32'd0, off_q};
				acc_foot = 1'b1;
			end
			ACC_WR_PRV_HDR: begin
				acc_addr = p_q[31:0];
				acc_wval = {32'd0, total_q[29:0], 1'b1, ph_q[0]};
			end
			ACC_WR_PRV_FT: begin
				acc_addr = p_q[31:0] + HDR_W + total_q - PB_W;
				acc_wval = {32'd0, p_q[31:0]};
				acc_foot = 1'b1;
			end
			default: acc_wr = 1'b0;
		endcase
	end

	// byte address of the current engine step, folded into the arena
	assign acc_sum  = base_q + 32'(cnt_q);
	assign acc_wrap = (acc_sum >= ARENA_W) ? acc_sum - ARENA_W : acc_sum;
	assign mem_addr = acc_wrap[AW-1:0];
	assign byte_s1  = use_rst_s1 ? rstb_s1 : mem_rd_q;

	always_ff @(posedge clk) begin
		if (eng_act_q) begin
			if (eng_wr_q)
				mem[mem_addr] <= wval_q[8*cnt_q[2:0] +: 8];
			else
				mem_rd_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_act_q  <= 1'b0;
			eng_wr_q   <= 1'b0;
			cnt_q      <= 4'd0;
			len_q      <= 4'd0;
			v_s1       <= 1'b0;
			last_s1    <= 1'b0;
			done_q     <= 1'b0;
			init_q     <= 4'd0;
			use_rst_s1 <= 1'b0;
		end else begin
			v_s1    <= eng_act_q;
			last_s1 <= eng_act_q && (cnt_q == len_q - 4'd1);
			done_q  <= last_s1;
			use_rst_s1 <= eng_act_q && !eng_wr_q && (mem_addr[AW-1:2] == '0) &&
				!init_q[mem_addr[1:0]];
			if (eng_act_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == len_q - 4'd1)
					eng_act_q <= 1'b0;
				if (eng_wr_q && (mem_addr[AW-1:2] == '0))
					init_q[mem_addr[1:0]] <= 1'b1;
			end else if (cmd.acc != ACC_NONE) begin
				eng_act_q <= 1'b1;
				eng_wr_q  <= acc_wr;
				cnt_q     <= 4'd0;
				len_q     <= acc_foot ? 4'(POINTER_BYTES) : 4'(HDR_BYTES);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cnt_q[2:0];
		wr_s1   <= eng_wr_q;
		rstb_s1 <= HDR0[8*mem_addr[1:0] +: 8];
		if (!eng_act_q && (cmd.acc != ACC_NONE)) begin
			base_q <= acc_addr;
			wval_q <= acc_wval;
			asm_q  <= 64'd0;
		end else if (v_s1 && !wr_s1) begin
			asm_q[8*idx_s1 +: 8] <= byte_s1;
		end
	end

	// walk register updates
	always_ff @(posedge clk) begin
		case (cmd.upd)
			UPD_LOAD: begin
				act_q     <= request.action;
				rel_q     <= request.release_offset;
				x_q       <= XW'(request.request_bytes) + XW'(ALIGN_BYTES - 1);
				off_q     <= 32'd0;
				payload_q <= 12'd0;
			end
			UPD_RND1: q_s1 <= XW'(prod_w >> SH);
			UPD_RND2: sz_q <= SZW'(q_s1) * SZW'(ALIGN_BYTES);
			UPD_RND3: begin
				if (SZW'(x_q) >= sz_q + SZW'(ALIGN_BYTES))
					sz_q <= sz_q + SZW'(ALIGN_BYTES);
			end
			UPD_CLAMP: begin
				if (sz_q < SZW'(MIN_BLOCK_BYTES))
					sz_q <= SZW'(MIN_BLOCK_BYTES);
			end
			UPD_LD_HDR: begin
				h_q   <= asm_q[31:0];
				end_q <= off_q + HDR_W + {2'b00, asm_q[31:2]};
			end
			UPD_ADV:   off_q <= end_q;
			UPD_LD_NH: nh_q  <= asm_q[31:0];
			UPD_TAKE: begin
				payload_q <= 12'(off_q + HDR_W);
			end
			UPD_SPLIT: begin
				payload_q <= 12'(noff_w + HDR_W);
			end
			UPD_LD_P:  p_q  <= asm_q;
			UPD_LD_PH: ph_q <= asm_q[31:0];
			UPD_MERGE: begin
				newsize_q <= size_w + merge_add;
				freed_q   <= 13'(size_w) + ((merge_add != 32'd0) ? 13'(HDR_BYTES) : 13'd0);
			end
			UPD_LD_PH2: begin
				ph_q    <= asm_q[31:0];
				total_q <= psize_w + newsize_q + HDR_W;
			end
			UPD_FREED4: freed_q <= freed_q + 13'(HDR_BYTES);
			UPD_FIN:    res_q   <= '{payload_offset: payload_q, status: cmd.st,
				free_bytes: ft_q[11:0]};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ft_q     <= 13'(ARENA_BYTES - HDR_BYTES);
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.upd == UPD_FIN);
			case (cmd.upd)
				UPD_TAKE:   ft_q <= ft_q - 13'(size_w);
				UPD_SPLIT:  ft_q <= ft_q - 13'(sz_w) - 13'(HDR_BYTES);
				UPD_FT_ADD: ft_q <= ft_q + freed_q;
				default: ;
			endcase
		end
	end

	assign flags.done      = done_q;
	assign flags.act       = act_q;
	assign flags.oversize  = (32'(sz_q) >= ARENA_W);
	assign flags.end_over  = (end_q > ARENA_W);
	assign flags.hfree     = h_q[1];
	assign flags.fits      = (size_w >= sz_w);
	assign flags.has_next  = (end_q < ARENA_W);
	assign flags.match     = ((off_q + HDR_W) == {20'd0, rel_q});
	assign flags.small_blk = (size_w < {sz_w[30:0], 1'b0} + HDR_W);
	assign flags.next_over = ((end_q + HDR_W + nsize_w) > ARENA_W);
	assign flags.has_prev  = h_q[0];
	assign flags.off_lt_pb = (off_q < PB_W);
	assign flags.p_bad     = (p_q >= {32'd0, off_q});
	assign flags.prev_bad  = !ph_q[1] || ((p_q[31:0] + HDR_W + psize_w) != off_q);

	assign response = res_q;
	assign strobe   = strobe_q;

endmodule

// ===== sim/tb.sv =====
// Testbench for the first-fit heap allocator core: directed table, then random traffic.
`timescale 1ns / 100ps

module tb;
	import ffha_pkg::*;

	localparam int unsigned ARENA     = 4096;
	localparam int unsigned ALIGN     = 4;
	localparam int unsigned MIN_BLOCK = 8;
	localparam int unsigned PTR_BYTES = 4;
	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;
	localparam int N_RANDOM = 550;
	localparam int N_CALM   = 100;

	typedef struct {
		logic        act;
		logic [15:0] req;
		logic [11:0] rel;
		bit          typed;
		result_t     res;
	} stim_row_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   request;
	result_t response;
	logic    strobe;

	// shadow of the arena and free-byte total
	logic [7:0]  heap_mem [0:ARENA-1];
	logic [12:0] heap_free;
	result_t     pending_results [$];
	int unsigned live_blocks [$];
	int unsigned freed_blocks [$];
	int          n_errors;

	first_fit_heap_allocator_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.response (response),
		.strobe   (strobe)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int unsigned rd_word(input int unsigned b);
		int unsigned v;
		v = 0;
		for (int k = 0; k < 4; k++)
			v |= 32'(heap_mem[(b + k) % ARENA]) << (8 * k);
		return v;
	endfunction

	function automatic void wr_hdr(input int unsigned b, input int unsigned pre,
			input int unsigned fr, input int unsigned size);
		int unsigned v;
		v = (pre & 1) | ((fr & 1) << 1) | ((size & 32'h3FFF_FFFF) << 2);
		for (int k = 0; k < 4; k++)
			heap_mem[(b + k) % ARENA] = 8'(v >> (8 * k));
	endfunction

	function automatic void wr_foot(input int unsigned b, input int unsigned target);
		for (int k = 0; k < PTR_BYTES; k++)
			heap_mem[(b + k) % ARENA] = (k < 4) ? 8'(target >> (8 * k)) : 8'd0;
	endfunction

	function automatic longint unsigned rd_foot(input int unsigned b);
		longint unsigned v;
		v = 0;
		for (int k = 0; k < PTR_BYTES && k < 8; k++)
			v |= 64'(heap_mem[(b + k) % ARENA]) << (8 * k);
		return v;
	endfunction

	function automatic void heap_reset();
		for (int i = 0; i < ARENA; i++)
			heap_mem[i] = 8'h00;
		wr_hdr(0, 0, 1, ARENA - HDR_BYTES);
		heap_free = 13'(ARENA - HDR_BYTES);
	endfunction

	function automatic logic [2:0] heap_alloc(input int unsigned req, output int unsigned pay);
		int unsigned sz, off, h, size, blk_end, nh, noff;
		pay = 0;
		sz = ((req + ALIGN - 1) / ALIGN) * ALIGN;
		if (sz >= ARENA)
			return ST_OVERSIZE;
		if (sz < MIN_BLOCK)
			sz = MIN_BLOCK;
		off = 0;
		while (off < ARENA) begin
			h = rd_word(off);
			size = h >> 2;
			blk_end = off + HDR_BYTES + size;
			if (blk_end > ARENA)
				return ST_CORRUPT;
			if (((h >> 1) & 1) == 0 || size < sz) begin
				off = blk_end;
				continue;
			end
			if (blk_end < ARENA) begin
				nh = rd_word(blk_end);
				wr_hdr(blk_end, 0, (nh >> 1) & 1, nh >> 2);
			end
			if (size < sz * 2 + HDR_BYTES) begin
				wr_hdr(off, h & 1, 0, size);
				heap_free = 13'(32'(heap_free) - size);
				pay = off + HDR_BYTES;
			end else begin
				noff = blk_end - HDR_BYTES - sz;
				wr_hdr(off, h & 1, 1, size - sz - HDR_BYTES);
				wr_foot(noff - PTR_BYTES, off);
				wr_hdr(noff, 1, 0, sz);
				heap_free = 13'(32'(heap_free) - sz - HDR_BYTES);
				pay = noff + HDR_BYTES;
			end
			return ST_OK;
		end
		return ST_NOSPACE;
	endfunction

	function automatic logic [2:0] heap_release(input int unsigned rel);
		int unsigned off, h, size, blk_end, nh, nsize, nfree, psize, poff, ph, newsize, freed;
		int unsigned total;
		bit has_next, has_prev;
		longint unsigned p;
		off = 0;
		while (off < ARENA) begin
			h = rd_word(off);
			size = h >> 2;
			blk_end = off + HDR_BYTES + size;
			nsize = 0;
			nfree = 0;
			psize = 0;
			poff = 0;
			if (blk_end > ARENA)
				return ST_CORRUPT;
			if (off + HDR_BYTES != rel) begin
				off = blk_end;
				continue;
			end
			if ((h >> 1) & 1)
				return ST_NOTFOUND;
			has_next = blk_end < ARENA;
			if (has_next) begin
				nh = rd_word(blk_end);
				nsize = nh >> 2;
				nfree = (nh >> 1) & 1;
				if (blk_end + HDR_BYTES + nsize > ARENA)
					return ST_CORRUPT;
			end
			has_prev = (h & 1) != 0;
			if (has_prev) begin
				if (off < PTR_BYTES)
					return ST_CORRUPT;
				p = rd_foot(off - PTR_BYTES);
				if (p >= 64'(off))
					return ST_CORRUPT;
				poff = 32'(p);
				ph = rd_word(poff);
				psize = ph >> 2;
				if (((ph >> 1) & 1) == 0 || poff + HDR_BYTES + psize != off)
					return ST_CORRUPT;
			end
			newsize = size;
			freed = size;
			if (has_next) begin
				wr_hdr(blk_end, 1, nfree, nsize);
				if (nfree) begin
					newsize += nsize + HDR_BYTES;
					freed += HDR_BYTES;
				end
			end
			wr_hdr(off, h & 1, 1, newsize);
			wr_foot(off + HDR_BYTES + newsize - PTR_BYTES, off);
			if (has_prev) begin
				ph = rd_word(poff);
				total = psize + newsize + HDR_BYTES;
				wr_hdr(poff, ph & 1, 1, total);
				wr_foot(poff + HDR_BYTES + total - PTR_BYTES, poff);
				freed += HDR_BYTES;
			end
			heap_free = 13'(32'(heap_free) + freed);
			return ST_OK;
		end
		return ST_NOTFOUND;
	endfunction

	function automatic result_t heap_step(input item_t it);
		result_t r;
		int unsigned pay;
		pay = 0;
		if (it.action == ACT_ALLOC) begin
			r.status = heap_alloc(32'(it.request_bytes), pay);
			if (r.status == ST_OK)
				live_blocks.push_back(pay);
		end else begin
			r.status = heap_release(32'(it.release_offset));
			if (r.status == ST_OK)
				freed_blocks.push_back(32'(it.release_offset));
		end
		r.payload_offset = 12'(pay);
		r.free_bytes = heap_free[11:0];
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	// issue one transaction and record what it must return
	task automatic issue(input item_t it, input bit typed, input result_t typed_res,
			input bit calm);
		result_t r;
		start <= 1'b1;
		request <= it;
		do
			@(posedge clk);
		while (busy);
		r = heap_step(it);
		pending_results.push_back(typed ? typed_res : r);
		if (!calm && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				report("unexpected transaction", int'(response.status), -1);
			end else begin
				want = pending_results.pop_front();
				if (response.payload_offset !== want.payload_offset)
					report("payload_offset", int'(response.payload_offset),
						int'(want.payload_offset));
				if (response.status !== want.status)
					report("status", int'(response.status), int'(want.status));
				if (response.free_bytes !== want.free_bytes)
					report("free_bytes", int'(response.free_bytes), int'(want.free_bytes));
			end
		end
	end

	function automatic stim_row_t row(input logic a, input int req, input int rel,
			input bit typed = 1'b0, input int pay = 0, input logic [2:0] st = ST_OK,
			input int fb = 0);
		stim_row_t s;
		s.act = a;
		s.req = 16'(req);
		s.rel = 12'(rel);
		s.typed = typed;
		s.res.payload_offset = 12'(pay);
		s.res.status = st;
		s.res.free_bytes = 12'(fb);
		return s;
	endfunction

	initial begin
		#40_000_000;
		$display("FAIL first_fit_heap_allocator_core");
		$finish;
	end

	initial begin
		stim_row_t   dir_rows [$];
		item_t       it;
		int unsigned pick, sel, wait_cycles;
		bit          calm;
		n_errors = 0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		heap_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_rows.push_back(row(ACT_ALLOC, 16'hFFFF, 12'hFFF, 1'b1, 0, ST_OVERSIZE, 4092));
		dir_rows.push_back(row(ACT_ALLOC, 4093, 0, 1'b1, 0, ST_OVERSIZE, 4092));
		dir_rows.push_back(row(ACT_ALLOC, 4092, 12'hAAA, 1'b1, 4, ST_OK, 0));
		dir_rows.push_back(row(ACT_ALLOC, 1, 0, 1'b1, 0, ST_NOSPACE, 0));
		dir_rows.push_back(row(ACT_RELEASE, 16'h5555, 4, 1'b1, 0, ST_OK, 4092));
		dir_rows.push_back(row(ACT_RELEASE, 0, 4, 1'b1, 0, ST_NOTFOUND, 4092));
		dir_rows.push_back(row(ACT_RELEASE, 16'hFFFF, 12'hFFF, 1'b1, 0, ST_NOTFOUND, 4092));
		dir_rows.push_back(row(ACT_RELEASE, 0, 0, 1'b1, 0, ST_NOTFOUND, 4092));
		dir_rows.push_back(row(ACT_ALLOC, 0, 12'h555, 1'b1, 4088, ST_OK, 4080));
		dir_rows.push_back(row(ACT_ALLOC, 5, 0));
		dir_rows.push_back(row(ACT_ALLOC, 100, 0));
		dir_rows.push_back(row(ACT_ALLOC, 2000, 0));
		dir_rows.push_back(row(ACT_ALLOC, 8, 0));
		// middle block, then the blocks above it, so the merge into a free previous block fires; offset 4 is a free block
		dir_rows.push_back(row(ACT_RELEASE, 0, 3972));
		dir_rows.push_back(row(ACT_RELEASE, 0, 4076));
		dir_rows.push_back(row(ACT_RELEASE, 0, 4));
		dir_rows.push_back(row(ACT_RELEASE, 0, 4088));
		dir_rows.push_back(row(ACT_ALLOC, 3, 0));
		dir_rows.push_back(row(ACT_ALLOC, 9, 0));
		dir_rows.push_back(row(ACT_ALLOC, 1024, 0));

		foreach (dir_rows[i]) begin
			it.action = dir_rows[i].act;
			it.request_bytes = dir_rows[i].req;
			it.release_offset = dir_rows[i].rel;
			issue(it, dir_rows[i].typed, dir_rows[i].res, 1'b0);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			calm = n >= N_RANDOM - N_CALM;
			it.request_bytes = 16'($urandom_range(0, 16'hFFFF));
			it.release_offset = 12'($urandom_range(0, 12'hFFF));
			if ($urandom_range(0, 99) < 55) begin
				it.action = ACT_ALLOC;
				sel = $urandom_range(0, 99);
				if (sel < 70)
					it.request_bytes = 16'($urandom_range(1, 64));
				else if (sel < 90)
					it.request_bytes = 16'($urandom_range(65, 600));
				else if (sel < 95)
					it.request_bytes = 16'($urandom_range(1000, 4092));
			end else begin
				it.action = ACT_RELEASE;
				sel = $urandom_range(0, 99);
				if (sel < 80 && live_blocks.size() > 0) begin
					pick = $urandom_range(0, live_blocks.size() - 1);
					it.release_offset = 12'(live_blocks[pick]);
					live_blocks.delete(pick);
				end else if (sel < 90 && freed_blocks.size() > 0) begin
					pick = $urandom_range(0, freed_blocks.size() - 1);
					it.release_offset = 12'(freed_blocks[pick]);
				end
			end
			issue(it, 1'b0, '0, calm);
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (pending_results.size() > 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (100) @(posedge clk);

		if (n_errors == 0 && pending_results.size() == 0) begin
			$display("PASS first_fit_heap_allocator_core");
		end else begin
			$display("FAIL first_fit_heap_allocator_core");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/ffha_pkg.sv
design/ffha_ctrl.sv
design/ffha_dp.sv
design/first_fit_heap_allocator_core.sv
sim/tb.sv
